// ===== hw/rtl/magnetometer_sample_calibrate_core_assert.svh =====
// Assertion macros shared by the magnetometer calibration RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef MAGNETOMETER_SAMPLE_CALIBRATE_CORE_ASSERT_SVH
`define MAGNETOMETER_SAMPLE_CALIBRATE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MSCAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MSCAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mscal_pkg.sv =====
// Package for the magnetometer calibration block: widths, constants,
// register indexes and the structs passed between pipeline modules. No dependencies.
package mscal_pkg;

  // Raw count to microtesla scale numerator (denominator folded into shifts).
  localparam logic signed [11:0] SCALE_NUM = 12'sd1229;
  // Bias added to the factory sensitivity byte.
  localparam logic [8:0] ASA_BIAS = 9'd128;

  localparam int RAW_W   = 16;
  localparam int M1_W    = 27;  // raw * 1229
  localparam int ASA_W   = 10;  // asa + 128 as a signed factor
  localparam int P_W     = 36;  // raw * 1229 * (asa + 128)
  localparam int ADJ_SH  = 4;   // times 16, then floor divide by 256
  localparam int VAL_W   = 32;
  localparam int GAIN_W  = 24;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = 57;
  localparam int GAIN_SH = 16;
  localparam int CAL_W   = PROD_W - GAIN_SH;

  // Five axis stages plus the remap / output stage.
  localparam int NUM_STAGES = 6;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS_ADJ = 3'd0,
    REG_OFFSET_X = 3'd1,
    REG_OFFSET_Y = 3'd2,
    REG_OFFSET_Z = 3'd3,
    REG_GAIN_X   = 3'd4,
    REG_GAIN_Y   = 3'd5,
    REG_GAIN_Z   = 3'd6
  } cfg_reg_t;

  // One calibrated chip axis after clipping.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } axis_res_t;

  // Body-frame result held in the output register.
  typedef struct packed {
    logic signed [VAL_W-1:0] body_x;
    logic signed [VAL_W-1:0] body_y;
    logic signed [VAL_W-1:0] body_z;
    logic                    saturated;
  } body_res_t;

endpackage

// ===== hw/rtl/mscal_if.sv =====
// Valid/ready channel interfaces of the magnetometer calibration block.
// Depends on mscal_pkg for the field widths.

interface mscal_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_low_byte;
  logic [7:0] x_high_byte;
  logic [7:0] y_low_byte;
  logic [7:0] y_high_byte;
  logic [7:0] z_low_byte;
  logic [7:0] z_high_byte;

  modport source (output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                  z_low_byte, z_high_byte, input ready);
  modport sink (input valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                z_low_byte, z_high_byte, output ready);
endinterface

interface mscal_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mscal_pkg::VAL_W-1:0] body_x;
  logic signed [mscal_pkg::VAL_W-1:0] body_y;
  logic signed [mscal_pkg::VAL_W-1:0] body_z;
  logic                                saturated;

  modport source (output valid, body_x, body_y, body_z, saturated, input ready);
  modport sink (input valid, body_x, body_y, body_z, saturated, output ready);
endinterface

interface mscal_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mscal_pkg::CFG_IDX_W-1:0]    index;
  logic [mscal_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/magnetometer_sample_calibrate_core.sv =====
// Top level of the magnetometer sample calibration block: configuration
// registers, pipeline control and the three axis datapaths.
// Depends on mscal_pkg, mscal_if.sv, mscal_axis, mscal_remap and the assert header.

// The block turns one raw three-axis magnetometer sample (six little-endian
// bytes) into a calibrated body-frame field in microtesla Q16.16. Each axis is
// scaled by 1229/4096, multiplied by its factory sensitivity (asa+128)/256,
// has its offset subtracted and is multiplied by its Q8.16 gain; the result
// is then remapped as body_x = -chip_y, body_y = chip_x, body_z = chip_z.
// Values that overflow 32 bits clip and raise saturated. The datapath is a
// six-stage pipeline of five axis stages and the output register, and a
// new sample may enter every cycle while the pipeline is not stalled. The
// widest stage holds the 33 by 24 bit gain multiply. When the result side
// stalls, the whole pipeline holds; the sample side's ready follows the
// output stage.
// Configuration writes are always ready and must be made while the block is
// empty, since the registers feed the pipeline directly.
`include "magnetometer_sample_calibrate_core_assert.svh"

module magnetometer_sample_calibrate_core (
  input logic           clk,
  input logic           rst,
  mscal_cfg_if.sink     cfg,
  mscal_in_if.sink      sample,
  mscal_out_if.source   result
);

  // Configuration registers, one per index.
  logic [23:0]                                sens_adj;
  logic signed [mscal_pkg::VAL_W-1:0]         offset_x;
  logic signed [mscal_pkg::VAL_W-1:0]         offset_y;
  logic signed [mscal_pkg::VAL_W-1:0]         offset_z;
  logic signed [mscal_pkg::GAIN_W-1:0]        gain_x;
  logic signed [mscal_pkg::GAIN_W-1:0]        gain_y;
  logic signed [mscal_pkg::GAIN_W-1:0]        gain_z;

  // Valid bit of each pipeline stage; the last one is the output register.
  logic [mscal_pkg::NUM_STAGES-1:0] stage_valid;
  logic                             advance;

  mscal_pkg::axis_res_t chip_x;
  mscal_pkg::axis_res_t chip_y;
  mscal_pkg::axis_res_t chip_z;
  mscal_pkg::body_res_t body;

  // Conditions watched by the assertions at the end of the module.
  logic out_blocked;
  logic y_at_min;

  assign cfg.ready = 1'b1;

  // Writes to an index past the last register are dropped by the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      sens_adj <= 24'h80_8080;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      gain_x   <= 24'sd65536;
      gain_y   <= 24'sd65536;
      gain_z   <= 24'sd65536;
    end else if (cfg.valid) begin
      case (cfg.index)
        mscal_pkg::REG_SENS_ADJ: sens_adj <= cfg.data[23:0];
        mscal_pkg::REG_OFFSET_X: offset_x <= $signed(cfg.data);
        mscal_pkg::REG_OFFSET_Y: offset_y <= $signed(cfg.data);
        mscal_pkg::REG_OFFSET_Z: offset_z <= $signed(cfg.data);
        mscal_pkg::REG_GAIN_X:   gain_x   <= $signed(cfg.data[mscal_pkg::GAIN_W-1:0]);
        mscal_pkg::REG_GAIN_Y:   gain_y   <= $signed(cfg.data[mscal_pkg::GAIN_W-1:0]);
        mscal_pkg::REG_GAIN_Z:   gain_z   <= $signed(cfg.data[mscal_pkg::GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // The pipeline moves as one unit whenever the output register is free or
  // being emptied this cycle; otherwise every stage holds its item.
  assign advance      = !stage_valid[mscal_pkg::NUM_STAGES-1] || result.ready;
  assign sample.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[mscal_pkg::NUM_STAGES-2:0], sample.valid};
    end
  end

  mscal_axis u_axis_x (
    .clk       (clk),
    .advance   (advance),
    .low_byte  (sample.x_low_byte),
    .high_byte (sample.x_high_byte),
    .asa       (sens_adj[7:0]),
    .offset    (offset_x),
    .gain      (gain_x),
    .res       (chip_x)
  );

  mscal_axis u_axis_y (
    .clk       (clk),
    .advance   (advance),
    .low_byte  (sample.y_low_byte),
    .high_byte (sample.y_high_byte),
    .asa       (sens_adj[15:8]),
    .offset    (offset_y),
    .gain      (gain_y),
    .res       (chip_y)
  );

  mscal_axis u_axis_z (
    .clk       (clk),
    .advance   (advance),
    .low_byte  (sample.z_low_byte),
    .high_byte (sample.z_high_byte),
    .asa       (sens_adj[23:16]),
    .offset    (offset_z),
    .gain      (gain_z),
    .res       (chip_z)
  );

  mscal_remap u_remap (
    .clk     (clk),
    .advance (advance),
    .chip_x  (chip_x),
    .chip_y  (chip_y),
    .chip_z  (chip_z),
    .body    (body)
  );

  assign result.valid     = stage_valid[mscal_pkg::NUM_STAGES-1];
  assign result.body_x    = body.body_x;
  assign result.body_y    = body.body_y;
  assign result.body_z    = body.body_z;
  assign result.saturated = body.saturated;

  assign out_blocked = result.valid && !result.ready;
  assign y_at_min    = stage_valid[mscal_pkg::NUM_STAGES-2] &&
                       (chip_y.value == mscal_pkg::S32_MIN);

  // A stalled pipeline must neither drop nor create items.
  `MSCAL_ASSERT_NEXT(a_stall_holds_valid, !advance, $stable(stage_valid), "valids moved in stall")
  // A waiting result must hold off new samples.
  `MSCAL_ASSERT_NOW(a_backpressure, out_blocked, !sample.ready, "input taken while blocked")
  // Negated chip y can never reach the most negative value.
  `MSCAL_ASSERT_NOW(a_body_x_range, result.valid, body.body_x != mscal_pkg::S32_MIN, "bad body_x")
  // Clipped chip y at the negative rail must show up as saturation.
  `MSCAL_ASSERT_NEXT(a_neg_clip_flag, advance && y_at_min, result.saturated, "clip not flagged")

endmodule

// ===== hw/rtl/mscal_axis.sv =====
// Five-stage calibration datapath for one chip axis: scale, sensitivity,
// offset, gain and clip. Depends on mscal_pkg.
module mscal_axis (
  input  logic                                clk,
  input  logic                                advance,
  input  logic [7:0]                          low_byte,
  input  logic [7:0]                          high_byte,
  input  logic [7:0]                          asa,
  input  logic signed [mscal_pkg::VAL_W-1:0]  offset,
  input  logic signed [mscal_pkg::GAIN_W-1:0] gain,
  output mscal_pkg::axis_res_t                res
);

  logic signed [mscal_pkg::RAW_W-1:0]  raw;
  logic signed [mscal_pkg::M1_W-1:0]   raw_ext;
  logic signed [mscal_pkg::M1_W-1:0]   m1_next;
  logic signed [mscal_pkg::M1_W-1:0]   m1;
  logic signed [mscal_pkg::ASA_W-1:0]  asa_factor;
  logic signed [mscal_pkg::P_W-1:0]    p_full;
  logic signed [mscal_pkg::VAL_W-1:0]  adj;
  logic signed [mscal_pkg::DIFF_W-1:0] diff;
  logic signed [mscal_pkg::PROD_W-1:0] prod;
  logic signed [mscal_pkg::CAL_W-1:0]  cal;
  logic                                cal_fits;
  mscal_pkg::axis_res_t                res_next;

  // Stage 1: form the signed count and multiply by the scale numerator.
  always_comb begin
    raw     = $signed({high_byte, low_byte});
    raw_ext = mscal_pkg::M1_W'(raw);
    m1_next = raw_ext * mscal_pkg::M1_W'(mscal_pkg::SCALE_NUM);
  end

  // Stage 2: the sensitivity factor; the result is floor(p / 16).
  always_comb begin
    asa_factor = $signed({1'b0, {1'b0, asa} + mscal_pkg::ASA_BIAS});
    p_full     = mscal_pkg::P_W'(m1) * mscal_pkg::P_W'(asa_factor);
  end

  // Stage 5 logic: floor shift by 16, then clip to 32 bits.
  always_comb begin
    cal      = prod[mscal_pkg::PROD_W-1:mscal_pkg::GAIN_SH];
    cal_fits = (cal[mscal_pkg::CAL_W-1:mscal_pkg::VAL_W-1] == '0) ||
               (cal[mscal_pkg::CAL_W-1:mscal_pkg::VAL_W-1] == '1);
    res_next.sat = !cal_fits;
    if (cal_fits) begin
      res_next.value = cal[mscal_pkg::VAL_W-1:0];
    end else if (cal[mscal_pkg::CAL_W-1]) begin
      res_next.value = mscal_pkg::S32_MIN;
    end else begin
      res_next.value = mscal_pkg::S32_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m1   <= m1_next;
      adj  <= p_full[mscal_pkg::ADJ_SH +: mscal_pkg::VAL_W];
      diff <= mscal_pkg::DIFF_W'(adj) - mscal_pkg::DIFF_W'(offset);
      prod <= mscal_pkg::PROD_W'(diff) * mscal_pkg::PROD_W'(gain);
      res  <= res_next;
    end
  end

endmodule

// ===== hw/rtl/mscal_remap.sv =====
// Output stage: maps calibrated chip axes to body axes and gathers the
// saturation flag into the output register. Depends on mscal_pkg.
module mscal_remap (
  input  logic                 clk,
  input  logic                 advance,
  input  mscal_pkg::axis_res_t chip_x,
  input  mscal_pkg::axis_res_t chip_y,
  input  mscal_pkg::axis_res_t chip_z,
  output mscal_pkg::body_res_t body
);

  logic                 y_is_min;
  mscal_pkg::body_res_t body_next;

  // Negating the most negative value cannot be represented, so it clips.
  always_comb begin
    y_is_min = (chip_y.value == mscal_pkg::S32_MIN);
    body_next.body_x    = y_is_min ? mscal_pkg::S32_MAX : -chip_y.value;
    body_next.body_y    = chip_x.value;
    body_next.body_z    = chip_z.value;
    body_next.saturated = chip_x.sat | chip_y.sat | chip_z.sat | y_is_min;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      body <= body_next;
    end
  end

endmodule

// ===== test/magnetometer_sample_calibrate_core_test.sv =====
// Self-checking testbench for magnetometer_sample_calibrate_core: random and directed
// samples over many register settings, checked against an in-bench fixed-point predictor.
// Depends on mscal_pkg, the channel interfaces in mscal_if.sv and the block's RTL.
module magnetometer_sample_calibrate_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. The block has six pipeline stages, so DRAIN_CYCLES quiet cycles
  // after the last result are enough to see anything stray come out.
  localparam int RESET_CYCLES     = 8;
  localparam int DRAIN_CYCLES     = 12;
  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 128;
  localparam int HOLD_PHASE       = 3;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int MAX_PRINTED      = 40;

  // Register index beyond the defined set; writes to it must change nothing.
  localparam logic [mscal_pkg::CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;

  // Fixed-point constants of the conversion. 1229/4096 in Q16.16 is an exact
  // multiply by 1229 * 16.
  localparam longint RAW_TO_UT_NUM  = 1229;
  localparam longint RAW_TO_Q16     = 16;
  localparam longint SENS_BIAS      = 128;
  localparam int     SENS_SHIFT     = 8;
  localparam int     GAIN_SHIFT     = 16;
  localparam longint S32_HI         = 2147483647;
  localparam longint S32_LO         = -longint'(2147483647) - 1;
  localparam logic [23:0] SENS_UNITY = 24'h808080;
  localparam logic [23:0] GAIN_UNITY = 24'h010000;
  localparam logic [23:0] GAIN_MAX   = 24'h7FFFFF;
  localparam logic [23:0] GAIN_MIN   = 24'h800000;
  localparam logic [31:0] OFFSET_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] OFFSET_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [7:0] x_lo;
    logic [7:0] x_hi;
    logic [7:0] y_lo;
    logic [7:0] y_hi;
    logic [7:0] z_lo;
    logic [7:0] z_hi;
  } raw_sample_t;

  logic clk;
  logic rst;

  mscal_cfg_if cfg_bus();
  mscal_in_if  sample_bus();
  mscal_out_if result_bus();

  magnetometer_sample_calibrate_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .sample (sample_bus),
    .result (result_bus)
  );

  // Calibration settings as the block should currently hold them.
  logic [23:0] sens_adjust;
  longint      chip_offset[3];
  longint      chip_gain[3];

  raw_sample_t          pending_samples[$];
  mscal_pkg::body_res_t expected_body[$];

  bit          offering;
  raw_sample_t current_sample;
  int          sender_gap;
  bit          sender_calm;
  int          receiver_hold;
  bit          receiver_calm;
  bit          long_hold_request;
  int          quiet_cycles;

  int samples_sent;
  int results_seen;
  int clipped_results;
  int register_writes;
  int settings_loaded;
  int input_stall_cycles;
  int mismatch_count;

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic longint clip_s32(longint v, inout bit sat);
    if (v > S32_HI) begin
      sat = 1'b1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      sat = 1'b1;
      return S32_LO;
    end
    return v;
  endfunction

  // One chip axis: scale the raw count to microtesla Q16.16, apply the
  // factory sensitivity, remove the offset and apply the gain. Every right
  // shift is on a signed 64-bit value, so it floors as the hardware does.
  // The widest product is about 2^55, well inside 64 bits.
  function automatic longint calibrate_chip_axis(logic [7:0] lo, logic [7:0] hi,
                                                 logic [7:0] asa, longint offset,
                                                 longint gain, inout bit sat);
    longint raw;
    longint scaled;
    longint adjusted;
    longint diff;
    raw      = longint'($signed({hi, lo}));
    scaled   = raw * RAW_TO_UT_NUM * RAW_TO_Q16;
    adjusted = (scaled * (longint'(asa) + SENS_BIAS)) >>> SENS_SHIFT;
    diff     = adjusted - offset;
    return clip_s32((diff * gain) >>> GAIN_SHIFT, sat);
  endfunction

  // Body frame: x is the negated chip y, y is chip x, z is chip z. The
  // negation is clipped again, which matters when chip y sits at -2^31.
  function automatic mscal_pkg::body_res_t predict_body_field(raw_sample_t s);
    mscal_pkg::body_res_t r;
    bit                   sat;
    longint               cx;
    longint               cy;
    longint               cz;
    longint               bx;
    sat = 1'b0;
    cx = calibrate_chip_axis(s.x_lo, s.x_hi, sens_adjust[7:0], chip_offset[0],
                             chip_gain[0], sat);
    cy = calibrate_chip_axis(s.y_lo, s.y_hi, sens_adjust[15:8], chip_offset[1],
                             chip_gain[1], sat);
    cz = calibrate_chip_axis(s.z_lo, s.z_hi, sens_adjust[23:16], chip_offset[2],
                             chip_gain[2], sat);
    bx = clip_s32(-cy, sat);
    r.body_x    = bx[31:0];
    r.body_y    = cx[31:0];
    r.body_z    = cz[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // Mirror of a register write. The 24-bit registers keep only the low bits
  // of the write data; an unknown index leaves everything alone.
  function automatic void note_register_write(logic [mscal_pkg::CFG_IDX_W-1:0] idx,
                                              logic [mscal_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mscal_pkg::REG_SENS_ADJ: sens_adjust = data[23:0];
      mscal_pkg::REG_OFFSET_X: chip_offset[0] = longint'($signed(data));
      mscal_pkg::REG_OFFSET_Y: chip_offset[1] = longint'($signed(data));
      mscal_pkg::REG_OFFSET_Z: chip_offset[2] = longint'($signed(data));
      mscal_pkg::REG_GAIN_X:   chip_gain[0] = longint'($signed(data[23:0]));
      mscal_pkg::REG_GAIN_Y:   chip_gain[1] = longint'($signed(data[23:0]));
      mscal_pkg::REG_GAIN_Z:   chip_gain[2] = longint'($signed(data[23:0]));
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Most gaps are absent or short, a few are long.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic raw_sample_t make_sample(logic [15:0] x, logic [15:0] y,
                                              logic [15:0] z);
    raw_sample_t s;
    s.x_lo = x[7:0];
    s.x_hi = x[15:8];
    s.y_lo = y[7:0];
    s.y_hi = y[15:8];
    s.z_lo = z[7:0];
    s.z_hi = z[15:8];
    return s;
  endfunction

  // Raw counts are mostly uniform; now and then an axis sits at a corner of
  // the 16-bit range.
  function automatic logic [15:0] random_count();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // The 24-bit registers get random upper data bits, which must be dropped.
  function automatic logic [31:0] pick_sensitivity();
    logic [31:0] data;
    data = $urandom;
    case ($urandom_range(0, 5))
      0: data[23:0] = 24'h000000;
      1: data[23:0] = 24'hFFFFFF;
      2: data[23:0] = SENS_UNITY;
      default: begin
      end
    endcase
    return data;
  endfunction

  function automatic logic [31:0] pick_offset();
    int small_offset;
    case ($urandom_range(0, 7))
      0: return OFFSET_MAX;
      1: return OFFSET_MIN;
      2: return $urandom;
      default: begin
        small_offset = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        return small_offset;
      end
    endcase
  endfunction

  // Gains near +/-1.0 keep most results in range; the extremes and fully
  // random gains drive the clipping paths.
  function automatic logic [31:0] pick_gain();
    logic [31:0] data;
    int          gain;
    data = $urandom;
    case ($urandom_range(0, 7))
      0: data[23:0] = GAIN_MAX;
      1: data[23:0] = GAIN_MIN;
      2: begin
      end
      default: begin
        gain = 65536 + int'($urandom_range(0, 65536)) - 32768;
        if ($urandom_range(0, 3) == 0) gain = -gain;
        data[23:0] = gain[23:0];
      end
    endcase
    return data;
  endfunction

  // Writes one register and returns at the edge that took it, with valid
  // still high so that back-to-back writes need no second assignment.
  task automatic write_register(logic [mscal_pkg::CFG_IDX_W-1:0] idx,
                                logic [mscal_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    note_register_write(idx, data);
    register_writes++;
  endtask

  task automatic load_setting(logic [31:0] sens, logic [31:0] off_x, logic [31:0] off_y,
                              logic [31:0] off_z, logic [31:0] gain_x,
                              logic [31:0] gain_y, logic [31:0] gain_z);
    write_register(mscal_pkg::REG_SENS_ADJ, sens);
    write_register(mscal_pkg::REG_OFFSET_X, off_x);
    write_register(mscal_pkg::REG_OFFSET_Y, off_y);
    write_register(mscal_pkg::REG_OFFSET_Z, off_z);
    write_register(mscal_pkg::REG_GAIN_X, gain_x);
    write_register(mscal_pkg::REG_GAIN_Y, gain_y);
    write_register(mscal_pkg::REG_GAIN_Z, gain_z);
    cfg_bus.valid <= 1'b0;
    settings_loaded++;
  endtask

  // The registers feed the pipeline directly, so they may only change once
  // every sample has been taken and every result has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || offering || expected_body.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Sample driver: offers queued items, with random gaps between them. The
  // expected result is worked out at the edge where an item is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      offering = 1'b0;
      sender_gap = 0;
      sample_bus.valid <= 1'b0;
    end else begin
      if (offering && sample_bus.ready) begin
        expected_body.push_back(predict_body_field(current_sample));
        samples_sent++;
        offering = 1'b0;
      end else if (offering) begin
        input_stall_cycles++;
      end
      if ($urandom_range(0, 63) == 0) sender_calm = !sender_calm;
      if (!offering) begin
        if (sender_gap > 0) begin
          sender_gap--;
        end else if (pending_samples.size() != 0) begin
          current_sample = pending_samples.pop_front();
          offering = 1'b1;
          sender_gap = sender_calm ? 0 : idle_length();
        end
      end
      sample_bus.valid <= offering;
      if (offering) begin
        sample_bus.x_low_byte  <= current_sample.x_lo;
        sample_bus.x_high_byte <= current_sample.x_hi;
        sample_bus.y_low_byte  <= current_sample.y_lo;
        sample_bus.y_high_byte <= current_sample.y_hi;
        sample_bus.z_low_byte  <= current_sample.z_lo;
        sample_bus.z_high_byte <= current_sample.z_hi;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: checks every taken result against the oldest
  // expectation and drives ready with random stalls, calm stretches and,
  // once, a long hold-off that backs the pipeline up into the sample side.
  // ---------------------------------------------------------------------
  task automatic check_result();
    mscal_pkg::body_res_t want;
    if (expected_body.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no sample outstanding",
                                results_seen));
    end else begin
      want = expected_body.pop_front();
      if (result_bus.body_x !== want.body_x)
        report_mismatch($sformatf("result %0d body_x got %0d want %0d", results_seen,
                                  result_bus.body_x, want.body_x));
      if (result_bus.body_y !== want.body_y)
        report_mismatch($sformatf("result %0d body_y got %0d want %0d", results_seen,
                                  result_bus.body_y, want.body_y));
      if (result_bus.body_z !== want.body_z)
        report_mismatch($sformatf("result %0d body_z got %0d want %0d", results_seen,
                                  result_bus.body_z, want.body_z));
      if (result_bus.saturated !== want.saturated)
        report_mismatch($sformatf("result %0d saturated got %b want %b", results_seen,
                                  result_bus.saturated, want.saturated));
      if (want.saturated) clipped_results++;
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    bit take;
    if (rst) begin
      receiver_hold = 0;
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) check_result();
      if ($urandom_range(0, 63) == 0) receiver_calm = !receiver_calm;
      if (long_hold_request) begin
        receiver_hold = LONG_HOLD_CYCLES;
        long_hold_request = 1'b0;
      end
      if (receiver_hold > 0) begin
        receiver_hold--;
        take = 1'b0;
      end else if (receiver_calm) begin
        take = 1'b1;
      end else begin
        receiver_hold = idle_length();
        take = (receiver_hold == 0);
      end
      result_bus.ready <= take;
    end
  end

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results still outstanding",
               quiet_cycles, expected_body.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    sample_bus.valid = 1'b0;
    sample_bus.x_low_byte = '0;
    sample_bus.x_high_byte = '0;
    sample_bus.y_low_byte = '0;
    sample_bus.y_high_byte = '0;
    sample_bus.z_low_byte = '0;
    sample_bus.z_high_byte = '0;
    result_bus.ready = 1'b0;
    long_hold_request = 1'b0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    quiet_cycles = 0;

    // Settings after reset: unity sensitivity, no offset, unity gain.
    sens_adjust = SENS_UNITY;
    for (int a = 0; a < 3; a++) begin
      chip_offset[a] = 0;
      chip_gain[a] = longint'(GAIN_UNITY);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: the corners of the raw count range and byte patterns
    // that separate the low byte from the high byte.
    pending_samples.push_back(make_sample(16'h0000, 16'h0000, 16'h0000));
    pending_samples.push_back(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_samples.push_back(make_sample(16'h8000, 16'h8000, 16'h8000));
    pending_samples.push_back(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_samples.push_back(make_sample(16'h00FF, 16'hFF00, 16'h5AA5));
    pending_samples.push_back(make_sample(16'h0001, 16'h8000, 16'h7FFF));
    wait_drained();

    // Calibrated chip y lands exactly on -2^31 for a raw count of -1: the
    // offset cancels all but that, so body_x must clip on the negation.
    // A write to the unused index goes first and must not disturb anything.
    write_register(UNUSED_REG_IDX, 32'hFFFF_FFFF);
    load_setting(SENS_UNITY, 32'd0, 32'd2147463984, 32'd0, GAIN_UNITY, GAIN_UNITY,
                 GAIN_UNITY);
    pending_samples.push_back(make_sample(16'h0000, 16'hFFFF, 16'h0000));
    pending_samples.push_back(make_sample(16'h1234, 16'hFFFE, 16'hFEDC));
    pending_samples.push_back(make_sample(16'h0000, 16'h0000, 16'h0000));
    wait_drained();

    // Largest sensitivity and gain magnitudes with offsets at their limits:
    // every axis overflows, chip x upward, chip y and z downward.
    load_setting({8'hA5, 24'hFFFFFF}, OFFSET_MIN, OFFSET_MAX, OFFSET_MIN,
                 {8'hFF, GAIN_MAX}, {8'h00, GAIN_MAX}, {8'h5A, GAIN_MIN});
    pending_samples.push_back(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_samples.push_back(make_sample(16'h8000, 16'h8000, 16'h8000));
    pending_samples.push_back(make_sample(16'h0000, 16'h0000, 16'h0000));
    pending_samples.push_back(make_sample(16'h8000, 16'h7FFF, 16'h0001));
    wait_drained();

    // Zero sensitivity byte (factor one half), the most negative gain, a
    // zero gain and the smallest positive gain.
    load_setting({8'hFF, 24'h000000}, OFFSET_MAX, OFFSET_MIN, 32'd0,
                 {8'h00, GAIN_MIN}, 32'hFF00_0000, 32'h0000_0001);
    pending_samples.push_back(make_sample(16'h7FFF, 16'h8000, 16'h7FFF));
    pending_samples.push_back(make_sample(16'h8000, 16'h7FFF, 16'hFFFF));
    pending_samples.push_back(make_sample(16'h0000, 16'h0000, 16'h0000));

    // Random part: a fresh setting per phase, then a batch of samples. In
    // one phase the receiver stops for a long stretch while the sender keeps
    // offering, so the pipeline fills and the sample side must stall.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      load_setting(pick_sensitivity(), pick_offset(), pick_offset(), pick_offset(),
                   pick_gain(), pick_gain(), pick_gain());
      if (phase == HOLD_PHASE) long_hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE)
        pending_samples.push_back(make_sample(random_count(), random_count(),
                                              random_count()));
    end
    wait_drained();

    $display("Covered %0d samples (%0d clipped) under %0d register settings, %0d writes.",
             samples_sent, clipped_results, settings_loaded, register_writes);
    $display("Sample side was held off for %0d cycles; %0d results checked, %0d mismatches.",
             input_stall_cycles, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
